### src/lsot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsot_pkg
// Shared types, widths and constants of the line segment overlap test.
// ----------------------------------------------------------------------------
package lsot_pkg;

    localparam int COORD_BITS    = 24;
    localparam int FRAC_BITS     = 10;
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int SUM_W         = PROD_W + 1;
    localparam int LEN_W         = PROD_W;

    localparam int HEAD_W        = 15;
    localparam int THR_W         = 16;
    localparam int THR2_W        = 2 * THR_W;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam int HEADING_RESET = (4 * 65536) / 360;
    localparam int DIST_RESET    = (1 << FRAC_BITS) / 10;

    // distance compare: values at or above 2**SQ_W always exceed
    localparam int SQ_W          = 2 * COORD_BITS + 1;
    localparam int SQ_LO         = (SQ_W + 1) / 2;
    localparam int SQ_HI         = SQ_W - SQ_LO;
    localparam int XX_W          = 2 * SQ_W;
    localparam int LEN_LO        = (LEN_W + 1) / 2;
    localparam int LEN_HI        = LEN_W - LEN_LO;
    localparam int YP_W          = THR2_W + LEN_LO;
    localparam int Y_W           = THR2_W + LEN_W;

    // angle unit
    localparam int NORM_TOP      = 59;
    localparam int CW            = NORM_TOP + 4;
    localparam int ZW            = 18;
    localparam int ANG_W         = 16;
    localparam int HALF_TURN     = 32768;
    localparam int CORDIC_STEPS  = 15;
    localparam int STEP_W        = 4;
    localparam int SHIFT_W       = 6;
    localparam int NGRP          = (SUM_W + 7) / 8;
    localparam int GRP_W         = 3;

    typedef enum logic [1:0] {
        VERDICT_OVERLAP = 2'd0,
        VERDICT_HEADING = 2'd1,
        VERDICT_DIST    = 2'd2,
        VERDICT_GAP     = 2'd3
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADING   = 2'd0,
        CFG_LINE_DIST = 2'd1,
        CFG_END_GAP   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ref_start_x;
        logic signed [COORD_BITS-1:0] ref_start_y;
        logic signed [COORD_BITS-1:0] ref_end_x;
        logic signed [COORD_BITS-1:0] ref_end_y;
        logic signed [COORD_BITS-1:0] new_start_x;
        logic signed [COORD_BITS-1:0] new_start_y;
        logic signed [COORD_BITS-1:0] new_end_x;
        logic signed [COORD_BITS-1:0] new_end_y;
    } in_t;

    typedef struct packed {
        logic     overlaps;
        verdict_t verdict;
    } out_t;

    typedef struct packed {
        logic [HEAD_W-1:0] max_heading_dev;
        logic [THR_W-1:0]  max_line_dist;
        logic [THR_W-1:0]  max_end_gap;
    } cfg_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] hc;
        logic signed [SUM_W-1:0] hd;
        logic signed [SUM_W-1:0] cra;
        logic signed [SUM_W-1:0] crb;
        logic signed [SUM_W-1:0] ts;
        logic signed [SUM_W-1:0] te;
        logic [LEN_W-1:0]        len2;
    } geom_t;

    typedef struct packed {
        logic dist_fail;
        logic gap_fail;
    } flag_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] hc;
        logic signed [SUM_W-1:0] hd;
        flag_t                   flags;
    } head_t;

    typedef struct packed {
        logic  head_fail;
        flag_t flags;
    } fail_t;

    // atan(2**-i) in 1/65536 turn
    function automatic logic [ZW-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [ZW-1:0] a;
        unique case (i)
            4'd0:    a = ZW'(8192);
            4'd1:    a = ZW'(4836);
            4'd2:    a = ZW'(2555);
            4'd3:    a = ZW'(1297);
            4'd4:    a = ZW'(651);
            4'd5:    a = ZW'(326);
            4'd6:    a = ZW'(163);
            4'd7:    a = ZW'(81);
            4'd8:    a = ZW'(41);
            4'd9:    a = ZW'(20);
            4'd10:   a = ZW'(10);
            4'd11:   a = ZW'(5);
            4'd12:   a = ZW'(3);
            4'd13:   a = ZW'(1);
            4'd14:   a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### src/lsot_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsot_geom
// Differences, products and cross/dot sums of the segment pair (3 stages).
// ----------------------------------------------------------------------------
module lsot_geom
    import lsot_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  in_t   in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output geom_t out_geom
);

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] ax;
        logic signed [DIFF_W-1:0] ay;
        logic signed [DIFF_W-1:0] bx;
        logic signed [DIFF_W-1:0] by;
        logic signed [DIFF_W-1:0] nx;
        logic signed [DIFF_W-1:0] ny;
    } diff_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] dxny;
        logic signed [PROD_W-1:0] dynx;
        logic signed [PROD_W-1:0] dxnx;
        logic signed [PROD_W-1:0] dyny;
        logic signed [PROD_W-1:0] dxay;
        logic signed [PROD_W-1:0] dyax;
        logic signed [PROD_W-1:0] dxby;
        logic signed [PROD_W-1:0] dybx;
        logic signed [PROD_W-1:0] dxax;
        logic signed [PROD_W-1:0] dyay;
        logic signed [PROD_W-1:0] dxbx;
        logic signed [PROD_W-1:0] dyby;
        logic signed [PROD_W-1:0] dxdx;
        logic signed [PROD_W-1:0] dydy;
    } prod_t;

    diff_t diff_reg, diff_next;
    prod_t prod_reg, prod_next;
    geom_t geom_reg, geom_next;
    logic  v1_reg, v2_reg, v3_reg;
    logic  en1, en2, en3;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        diff_next.dx = DIFF_W'(in_item.ref_end_x)   - DIFF_W'(in_item.ref_start_x);
        diff_next.dy = DIFF_W'(in_item.ref_end_y)   - DIFF_W'(in_item.ref_start_y);
        diff_next.ax = DIFF_W'(in_item.new_start_x) - DIFF_W'(in_item.ref_start_x);
        diff_next.ay = DIFF_W'(in_item.new_start_y) - DIFF_W'(in_item.ref_start_y);
        diff_next.bx = DIFF_W'(in_item.new_end_x)   - DIFF_W'(in_item.ref_start_x);
        diff_next.by = DIFF_W'(in_item.new_end_y)   - DIFF_W'(in_item.ref_start_y);
        diff_next.nx = DIFF_W'(in_item.new_end_x)   - DIFF_W'(in_item.new_start_x);
        diff_next.ny = DIFF_W'(in_item.new_end_y)   - DIFF_W'(in_item.new_start_y);
    end

    always_comb
    begin
        prod_next.dxny = PROD_W'(diff_reg.dx) * PROD_W'(diff_reg.ny);
        prod_next.dynx = PROD_W'(diff_reg.dy) * PROD_W'(diff_reg.nx);
        prod_next.dxnx = PROD_W'(diff_reg.dx) * PROD_W'(diff_reg.nx);
        prod_next.dyny = PROD_W'(diff_reg.dy) * PROD_W'(diff_reg.ny);
        prod_next.dxay = PROD_W'(diff_reg.dx) * PROD_W'(diff_reg.ay);
        prod_next.dyax = PROD_W'(diff_reg.dy) * PROD_W'(diff_reg.ax);
        prod_next.dxby = PROD_W'(diff_reg.dx) * PROD_W'(diff_reg.by);
        prod_next.dybx = PROD_W'(diff_reg.dy) * PROD_W'(diff_reg.bx);
        prod_next.dxax = PROD_W'(diff_reg.dx) * PROD_W'(diff_reg.ax);
        prod_next.dyay = PROD_W'(diff_reg.dy) * PROD_W'(diff_reg.ay);
        prod_next.dxbx = PROD_W'(diff_reg.dx) * PROD_W'(diff_reg.bx);
        prod_next.dyby = PROD_W'(diff_reg.dy) * PROD_W'(diff_reg.by);
        prod_next.dxdx = PROD_W'(diff_reg.dx) * PROD_W'(diff_reg.dx);
        prod_next.dydy = PROD_W'(diff_reg.dy) * PROD_W'(diff_reg.dy);
    end

    always_comb
    begin
        geom_next.hc   = SUM_W'(prod_reg.dxny) - SUM_W'(prod_reg.dynx);
        geom_next.hd   = SUM_W'(prod_reg.dxnx) + SUM_W'(prod_reg.dyny);
        geom_next.cra  = SUM_W'(prod_reg.dxay) - SUM_W'(prod_reg.dyax);
        geom_next.crb  = SUM_W'(prod_reg.dxby) - SUM_W'(prod_reg.dybx);
        geom_next.ts   = SUM_W'(prod_reg.dxax) + SUM_W'(prod_reg.dyay);
        geom_next.te   = SUM_W'(prod_reg.dxbx) + SUM_W'(prod_reg.dyby);
        geom_next.len2 = $unsigned(prod_reg.dxdx) + $unsigned(prod_reg.dydy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid) diff_reg <= diff_next;
        if (en2 && v1_reg)   prod_reg <= prod_next;
        if (en3 && v2_reg)   geom_reg <= geom_next;
    end

    assign out_valid = v3_reg;
    assign out_geom  = geom_reg;

endmodule

### src/lsot_thresh.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsot_thresh
// Line distance and end gap tests as exact squared compares (4 stages).
// ----------------------------------------------------------------------------
module lsot_thresh
    import lsot_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  geom_t in_geom,
    output logic  out_valid,
    input  logic  out_ready,
    output head_t out_head
);

    // operand slots: start endpoint, end endpoint, end gap
    localparam int NX = 3;

    typedef struct packed {
        logic signed [SUM_W-1:0]    hc;
        logic signed [SUM_W-1:0]    hd;
        logic [NX-1:0][SQ_W-1:0]    x;
        logic [NX-1:0]              big;
        logic                       gap_chk;
        logic [LEN_W-1:0]           len2;
        logic [THR2_W-1:0]          t2d;
        logic [THR2_W-1:0]          t2g;
    } t1_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]        hc;
        logic signed [SUM_W-1:0]        hd;
        logic [NX-1:0][2*SQ_HI-1:0]     hh;
        logic [NX-1:0][SQ_HI+SQ_LO-1:0] hl;
        logic [NX-1:0][2*SQ_LO-1:0]     ll;
        logic [1:0][YP_W-1:0]           yh;
        logic [1:0][YP_W-1:0]           yl;
        logic [NX-1:0]                  big;
        logic                           gap_chk;
    } t2_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] hc;
        logic signed [SUM_W-1:0] hd;
        logic [NX-1:0][XX_W-1:0] xx;
        logic [1:0][Y_W-1:0]     yy;
        logic [NX-1:0]           big;
        logic                    gap_chk;
    } t3_t;

    t1_t   t1_reg, t1_next;
    t2_t   t2_reg, t2_next;
    t3_t   t3_reg, t3_next;
    head_t t4_reg, t4_next;
    logic  v1_reg, v2_reg, v3_reg, v4_reg;
    logic  en1, en2, en3, en4;

    logic [SUM_W-1:0]        mag_a, mag_b, gap;
    logic signed [SUM_W:0]   gdiff;
    logic [NX-1:0][SUM_W-1:0] xm;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // magnitudes and gap selection
    always_comb
    begin
        mag_a = in_geom.cra[SUM_W-1] ? SUM_W'(-in_geom.cra) : in_geom.cra;
        mag_b = in_geom.crb[SUM_W-1] ? SUM_W'(-in_geom.crb) : in_geom.crb;
        gdiff = $signed({in_geom.ts[SUM_W-1], in_geom.ts}) - $signed({2'b00, in_geom.len2});
        if (in_geom.ts[SUM_W-1])
        begin
            t1_next.gap_chk = in_geom.te[SUM_W-1];
            gap             = SUM_W'(-in_geom.te);
        end
        else
        begin
            t1_next.gap_chk = !gdiff[SUM_W] && (gdiff != '0);
            gap             = gdiff[SUM_W-1:0];
        end
        xm[0] = mag_a;
        xm[1] = mag_b;
        xm[2] = gap;
        for (int k = 0; k < NX; k++)
        begin
            t1_next.big[k] = |xm[k][SUM_W-1:SQ_W];
            t1_next.x[k]   = xm[k][SQ_W-1:0];
        end
        t1_next.hc   = in_geom.hc;
        t1_next.hd   = in_geom.hd;
        t1_next.len2 = in_geom.len2;
        t1_next.t2d  = THR2_W'(cfg.max_line_dist) * THR2_W'(cfg.max_line_dist);
        t1_next.t2g  = THR2_W'(cfg.max_end_gap) * THR2_W'(cfg.max_end_gap);
    end

    // partial products
    always_comb
    begin
        for (int k = 0; k < NX; k++)
        begin
            t2_next.hh[k] = (2*SQ_HI)'(t1_reg.x[k][SQ_W-1:SQ_LO])
                          * (2*SQ_HI)'(t1_reg.x[k][SQ_W-1:SQ_LO]);
            t2_next.hl[k] = (SQ_HI+SQ_LO)'(t1_reg.x[k][SQ_W-1:SQ_LO])
                          * (SQ_HI+SQ_LO)'(t1_reg.x[k][SQ_LO-1:0]);
            t2_next.ll[k] = (2*SQ_LO)'(t1_reg.x[k][SQ_LO-1:0])
                          * (2*SQ_LO)'(t1_reg.x[k][SQ_LO-1:0]);
        end
        t2_next.yh[0]   = t1_reg.t2d * YP_W'(t1_reg.len2[LEN_W-1:LEN_LO]);
        t2_next.yl[0]   = t1_reg.t2d * YP_W'(t1_reg.len2[LEN_LO-1:0]);
        t2_next.yh[1]   = t1_reg.t2g * YP_W'(t1_reg.len2[LEN_W-1:LEN_LO]);
        t2_next.yl[1]   = t1_reg.t2g * YP_W'(t1_reg.len2[LEN_LO-1:0]);
        t2_next.big     = t1_reg.big;
        t2_next.gap_chk = t1_reg.gap_chk;
        t2_next.hc      = t1_reg.hc;
        t2_next.hd      = t1_reg.hd;
    end

    // assemble the squares
    always_comb
    begin
        for (int k = 0; k < NX; k++)
        begin
            t3_next.xx[k] = (XX_W'(t2_reg.hh[k]) << (2 * SQ_LO))
                          + (XX_W'(t2_reg.hl[k]) << (SQ_LO + 1))
                          + XX_W'(t2_reg.ll[k]);
        end
        for (int j = 0; j < 2; j++)
        begin
            t3_next.yy[j] = (Y_W'(t2_reg.yh[j]) << LEN_LO) + Y_W'(t2_reg.yl[j]);
        end
        t3_next.big     = t2_reg.big;
        t3_next.gap_chk = t2_reg.gap_chk;
        t3_next.hc      = t2_reg.hc;
        t3_next.hd      = t2_reg.hd;
    end

    always_comb
    begin
        t4_next.hc = t3_reg.hc;
        t4_next.hd = t3_reg.hd;
        t4_next.flags.dist_fail = t3_reg.big[0] || (t3_reg.xx[0] > XX_W'(t3_reg.yy[0]))
                               || t3_reg.big[1] || (t3_reg.xx[1] > XX_W'(t3_reg.yy[0]));
        t4_next.flags.gap_fail  = t3_reg.gap_chk
                               && (t3_reg.big[2] || (t3_reg.xx[2] > XX_W'(t3_reg.yy[1])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid) t1_reg <= t1_next;
        if (en2 && v1_reg)   t2_reg <= t2_next;
        if (en3 && v2_reg)   t3_reg <= t3_next;
        if (en4 && v3_reg)   t4_reg <= t4_next;
    end

    assign out_valid = v4_reg;
    assign out_head  = t4_reg;

endmodule

### src/lsot_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsot_cordic
// Heading difference: normalize (cross, dot), fifteen vectoring steps,
// wrap and compare against the heading limit (20 stages).
// ----------------------------------------------------------------------------
module lsot_cordic
    import lsot_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [HEAD_W-1:0] max_heading_dev,
    input  logic              in_valid,
    output logic              in_ready,
    input  head_t             in_head,
    output logic              out_valid,
    input  logic              out_ready,
    output fail_t             out_fail
);

    localparam int PAD_W = NGRP * 8;

    typedef struct packed {
        logic [SUM_W-1:0] mc;
        logic [SUM_W-1:0] md;
        logic [SUM_W-1:0] m;
        logic             flip;
        logic             hd_neg;
        flag_t            flags;
    } c1_t;

    typedef struct packed {
        logic [SUM_W-1:0] mc;
        logic [SUM_W-1:0] md;
        logic [GRP_W-1:0] grp;
        logic [7:0]       gbyte;
        logic             flip;
        logic             hd_neg;
        flag_t            flags;
    } c2_t;

    typedef struct packed {
        logic [SUM_W-1:0]   mc;
        logic [SUM_W-1:0]   md;
        logic [SHIFT_W-1:0] shamt;
        logic               flip;
        logic               hd_neg;
        flag_t              flags;
    } c3_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        flag_t                flags;
    } cst_t;

    c1_t   c1_reg, c1_next;
    c2_t   c2_reg, c2_next;
    c3_t   c3_reg, c3_next;
    cst_t  stg_reg  [0:CORDIC_STEPS];
    cst_t  stg_next [0:CORDIC_STEPS];
    fail_t fin_reg, fin_next;

    logic                  v1_reg, v2_reg, v3_reg, vf_reg;
    logic [CORDIC_STEPS:0] sv_reg;
    logic [CORDIC_STEPS:0] sen;
    logic                  en1, en2, en3, enf;

    logic [SUM_W-1:0] abs_c, abs_d;
    logic [PAD_W-1:0] mpad;
    logic [3:0]       blen;
    logic [6:0]       nbits;
    logic [6:0]       shift_full;
    logic [CW-1:0]    xmag, ymag;
    logic [ANG_W-1:0] wrap_z, mag_z;

    assign enf = !vf_reg || out_ready;
    assign en3 = !v3_reg || sen[0];
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    // magnitudes and the larger one
    always_comb
    begin
        abs_c = in_head.hc[SUM_W-1] ? SUM_W'(-in_head.hc) : in_head.hc;
        abs_d = in_head.hd[SUM_W-1] ? SUM_W'(-in_head.hd) : in_head.hd;
        c1_next.mc     = abs_c;
        c1_next.md     = abs_d;
        c1_next.m      = (abs_c > abs_d) ? abs_c : abs_d;
        c1_next.flip   = in_head.hc[SUM_W-1] ^ in_head.hd[SUM_W-1];
        c1_next.hd_neg = in_head.hd[SUM_W-1];
        c1_next.flags  = in_head.flags;
    end

    // coarse search: highest nonzero byte
    always_comb
    begin
        mpad          = PAD_W'(c1_reg.m);
        c2_next.grp   = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (|mpad[g*8 +: 8]) c2_next.grp = GRP_W'(g);
        end
        c2_next.gbyte  = mpad[c2_next.grp*8 +: 8];
        c2_next.mc     = c1_reg.mc;
        c2_next.md     = c1_reg.md;
        c2_next.flip   = c1_reg.flip;
        c2_next.hd_neg = c1_reg.hd_neg;
        c2_next.flags  = c1_reg.flags;
    end

    // fine search and shift amount that puts the top bit at NORM_TOP - 1
    always_comb
    begin
        blen = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (c2_reg.gbyte[b]) blen = 4'(b + 1);
        end
        nbits = (c2_reg.gbyte == '0) ? 7'd0 : ({1'b0, c2_reg.grp, 3'b000} + 7'(blen));
        shift_full     = 7'(NORM_TOP) - nbits;
        c3_next.shamt  = shift_full[SHIFT_W-1:0];
        c3_next.mc     = c2_reg.mc;
        c3_next.md     = c2_reg.md;
        c3_next.flip   = c2_reg.flip;
        c3_next.hd_neg = c2_reg.hd_neg;
        c3_next.flags  = c2_reg.flags;
    end

    // scale; a negative dot folds into a half-turn start
    always_comb
    begin
        xmag = CW'(c3_reg.md) << c3_reg.shamt;
        ymag = CW'(c3_reg.mc) << c3_reg.shamt;
        stg_next[0].x     = xmag;
        stg_next[0].y     = c3_reg.flip ? -$signed(ymag) : $signed(ymag);
        stg_next[0].z     = c3_reg.hd_neg ? ZW'(HALF_TURN) : '0;
        stg_next[0].flags = c3_reg.flags;
    end

    for (genvar k = 0; k <= CORDIC_STEPS; k++) begin : g_stage
        if (k == CORDIC_STEPS) begin : g_last
            assign sen[k] = !sv_reg[k] || enf;
        end
        else begin : g_mid
            assign sen[k] = !sv_reg[k] || sen[k+1];
        end

        if (k > 0) begin : g_step
            logic signed [CW-1:0] ys, xs;
            always_comb
            begin
                xs = stg_reg[k-1].x >>> (k - 1);
                ys = stg_reg[k-1].y >>> (k - 1);
                stg_next[k] = stg_reg[k-1];
                if (!stg_reg[k-1].y[CW-1] && (stg_reg[k-1].y != '0))
                begin
                    stg_next[k].x = stg_reg[k-1].x + ys;
                    stg_next[k].y = stg_reg[k-1].y - xs;
                    stg_next[k].z = stg_reg[k-1].z + $signed(atan_turn(STEP_W'(k - 1)));
                end
                else if (stg_reg[k-1].y[CW-1])
                begin
                    stg_next[k].x = stg_reg[k-1].x - ys;
                    stg_next[k].y = stg_reg[k-1].y + xs;
                    stg_next[k].z = stg_reg[k-1].z - $signed(atan_turn(STEP_W'(k - 1)));
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k] <= 1'b0;
            end
            else if (sen[k])
            begin
                if (k == 0) sv_reg[k] <= v3_reg;
                else        sv_reg[k] <= sv_reg[(k > 0) ? k - 1 : 0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (sen[k] && ((k == 0) ? v3_reg : sv_reg[(k > 0) ? k - 1 : 0]))
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // wrap to a signed 16-bit angle and take its magnitude
    always_comb
    begin
        wrap_z = stg_reg[CORDIC_STEPS].z[ANG_W-1:0];
        mag_z  = wrap_z[ANG_W-1] ? (~wrap_z + ANG_W'(1)) : wrap_z;
        fin_next.head_fail = mag_z > ANG_W'(max_heading_dev);
        fin_next.flags     = stg_reg[CORDIC_STEPS].flags;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (enf) vf_reg <= sv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)               c1_reg  <= c1_next;
        if (en2 && v1_reg)                 c2_reg  <= c2_next;
        if (en3 && v2_reg)                 c3_reg  <= c3_next;
        if (enf && sv_reg[CORDIC_STEPS])   fin_reg <= fin_next;
    end

    assign out_valid = vf_reg;
    assign out_fail  = fin_reg;

endmodule

### src/line_segment_overlap_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_segment_overlap_test_unit
// Judges whether a new wall segment lies on a reference segment: heading,
// line distance and end gap tests, first failing test sets the verdict.
//
//   channel   signals                              direction  width
//   item      item_valid / item_stall / item       in         8 x 24
//   result    result_valid / result_stall / result out        1 + 2
//   config    cfg_write / cfg_index / cfg_data     in         2 + 16
//
// One transaction enters per cycle while item_stall is low, then passes the
// fifteen-step angle unit plus geometry, distance compare and output stages.
// Reset restores the limits to 728, 102 and 102 and empties the pipeline.
// A stalled result holds; upstream stages keep filling bubbles, and
// item_stall rises only when every stage holds a transaction.
// ----------------------------------------------------------------------------
module line_segment_overlap_test_unit
    import lsot_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_t                   item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_t                  result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    geom_t geom;
    head_t head;
    fail_t fail;
    logic  geom_ready, geom_valid;
    logic  head_ready, head_valid;
    logic  fail_ready, fail_valid;
    logic  result_valid_reg;
    out_t  result_reg, result_next;
    logic  out_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_heading_dev <= HEAD_W'(HEADING_RESET);
            cfg_reg.max_line_dist   <= THR_W'(DIST_RESET);
            cfg_reg.max_end_gap     <= THR_W'(DIST_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HEADING:   cfg_reg.max_heading_dev <= cfg_data[HEAD_W-1:0];
                CFG_LINE_DIST: cfg_reg.max_line_dist   <= cfg_data[THR_W-1:0];
                CFG_END_GAP:   cfg_reg.max_end_gap     <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    lsot_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_ready  (geom_ready),
        .in_item   (item),
        .out_valid (geom_valid),
        .out_ready (head_ready),
        .out_geom  (geom)
    );

    lsot_thresh u_thresh (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (geom_valid),
        .in_ready  (head_ready),
        .in_geom   (geom),
        .out_valid (head_valid),
        .out_ready (fail_ready),
        .out_head  (head)
    );

    lsot_cordic u_cordic (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_heading_dev (cfg_reg.max_heading_dev),
        .in_valid        (head_valid),
        .in_ready        (fail_ready),
        .in_head         (head),
        .out_valid       (fail_valid),
        .out_ready       (out_en),
        .out_fail        (fail)
    );

    assign out_en     = !result_valid_reg || !result_stall;
    assign item_stall = !geom_ready;

    // first failing test wins
    always_comb
    begin
        priority if (fail.head_fail)       result_next.verdict = VERDICT_HEADING;
        else if (fail.flags.dist_fail)     result_next.verdict = VERDICT_DIST;
        else if (fail.flags.gap_fail)      result_next.verdict = VERDICT_GAP;
        else                               result_next.verdict = VERDICT_OVERLAP;
        result_next.overlaps = (result_next.verdict == VERDICT_OVERLAP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            result_valid_reg <= fail_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && fail_valid) result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.overlaps == (result.verdict == VERDICT_OVERLAP)))
        else $error("overlaps flag disagrees with verdict");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled while the output side is free");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !fail_valid) |=> !result_valid)
        else $error("result repeated after it was taken");
`endif

endmodule

### tb/tb_line_segment_overlap_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_segment_overlap_test_unit
// Self-checking bench for the segment overlap judge. An in-bench predictor
// computes the heading, line distance and end gap verdict of every accepted
// transaction; a checker compares each result with the oldest prediction.
// Directed corner cases are followed by near-collinear pairs with random
// content and random noise under several limit settings, with random
// idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_line_segment_overlap_test_unit;
    import lsot_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    in_t                   item;
    logic                  result_valid;
    logic                  result_stall;
    out_t                  result;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // limits as the block should hold them
    int unsigned lim_heading;
    int unsigned lim_line_dist;
    int unsigned lim_end_gap;

    out_t expected_results[$];
    int   error_count;
    bit   quiet;
    bit   hold_off_req;
    int   hold_off_left;

    line_segment_overlap_test_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int unsigned heading_error(longint cr, longint dt);
        int          atan_tab[CORDIC_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163,
                                                81, 41, 20, 10, 5, 3, 1, 1};
        longint      mc;
        longint      md;
        longint      m;
        longint      x;
        longint      y;
        longint      nx;
        longint      ny;
        int          n;
        int          z;
        int          w;
        int          sz;
        mc = (cr < 0) ? -cr : cr;
        md = (dt < 0) ? -dt : dt;
        m  = (mc > md) ? mc : md;
        if (m == 0)
            return 0;
        n = 0;
        while (m != 0)
        begin
            n++;
            m = m >> 1;
        end
        x = dt <<< (NORM_TOP - n);
        y = cr <<< (NORM_TOP - n);
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_tab[i];
            end
            else if (y < 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_tab[i];
            end
            else
            begin
                nx = x;
                ny = y;
            end
            x = nx;
            y = ny;
        end
        w  = z & 16'hFFFF;
        sz = (w >= 32768) ? w - 65536 : w;
        return (sz < 0) ? -sz : sz;
    endfunction

    // true when x / sqrt(len2) is above thr
    function automatic bit exceeds_limit(longint x, int unsigned thr, longint len2);
        logic [127:0] xx;
        logic [127:0] yy;
        if (x >= (64'sd1 <<< 49))
            return 1'b1;
        xx = 128'(x) * 128'(x);
        yy = 128'(thr) * 128'(thr) * 128'(len2);
        return xx > yy;
    endfunction

    function automatic verdict_t predict_verdict(in_t p);
        longint sx;
        longint sy;
        longint dx;
        longint dy;
        longint ax;
        longint ay;
        longint bx;
        longint by;
        longint nx;
        longint ny;
        longint len2;
        longint ts;
        longint te;
        longint cra;
        longint crb;
        sx   = p.ref_start_x;
        sy   = p.ref_start_y;
        dx   = longint'(p.ref_end_x) - sx;
        dy   = longint'(p.ref_end_y) - sy;
        ax   = longint'(p.new_start_x) - sx;
        ay   = longint'(p.new_start_y) - sy;
        bx   = longint'(p.new_end_x) - sx;
        by   = longint'(p.new_end_y) - sy;
        nx   = longint'(p.new_end_x) - longint'(p.new_start_x);
        ny   = longint'(p.new_end_y) - longint'(p.new_start_y);
        len2 = dx * dx + dy * dy;
        if (heading_error(dx * ny - dy * nx, dx * nx + dy * ny) > lim_heading)
            return VERDICT_HEADING;
        cra = dx * ay - dy * ax;
        crb = dx * by - dy * bx;
        if (cra < 0) cra = -cra;
        if (crb < 0) crb = -crb;
        if (exceeds_limit(cra, lim_line_dist, len2) || exceeds_limit(crb, lim_line_dist, len2))
            return VERDICT_DIST;
        ts = dx * ax + dy * ay;
        te = dx * bx + dy * by;
        if (ts < 0)
        begin
            if (te < 0)
                return exceeds_limit(-te, lim_end_gap, len2) ? VERDICT_GAP : VERDICT_OVERLAP;
            return VERDICT_OVERLAP;
        end
        if (ts > len2)
            return exceeds_limit(ts - len2, lim_end_gap, len2) ? VERDICT_GAP : VERDICT_OVERLAP;
        return VERDICT_OVERLAP;
    endfunction

    // ------------------------------------------------------------------
    // result checker and receiver stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction %p", result);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.overlaps !== want.overlaps)
                begin
                    $error("overlaps: expected %0b, actual %0b", want.overlaps, result.overlaps);
                    error_count++;
                end
                if (result.verdict !== want.verdict)
                begin
                    $error("verdict: expected %0d, actual %0d", want.verdict, result.verdict);
                    error_count++;
                end
            end
        end
        if (hold_off_req)
        begin
            hold_off_req  = 1'b0;
            hold_off_left = 300;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= !quiet && ($urandom_range(99) < 15);
    end

    // ------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------
    task automatic send_item(in_t p);
        out_t o;
        item       <= p;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        o.verdict  = predict_verdict(p);
        o.overlaps = (o.verdict == VERDICT_OVERLAP);
        expected_results = {expected_results, o};
        if (!quiet && $urandom_range(99) < 15)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_HEADING:   lim_heading   = data & 16'h7FFF;
            CFG_LINE_DIST: lim_line_dist = data;
            CFG_END_GAP:   lim_end_gap   = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic in_t build_pair(longint rsx, longint rsy, longint rex, longint rey,
                                       longint nsx, longint nsy, longint nex, longint ney);
        in_t p;
        p.ref_start_x = rsx[COORD_BITS-1:0];
        p.ref_start_y = rsy[COORD_BITS-1:0];
        p.ref_end_x   = rex[COORD_BITS-1:0];
        p.ref_end_y   = rey[COORD_BITS-1:0];
        p.new_start_x = nsx[COORD_BITS-1:0];
        p.new_start_y = nsy[COORD_BITS-1:0];
        p.new_end_x   = nex[COORD_BITS-1:0];
        p.new_end_y   = ney[COORD_BITS-1:0];
        return p;
    endfunction

    // new segment along the reference line, fractions in 1/1024 of d, plus small offsets
    function automatic in_t near_pair(int spread, int noise);
        longint sx;
        longint sy;
        longint dx;
        longint dy;
        longint fs;
        longint fe;
        longint t;
        sx = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        sy = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        dx = $signed($urandom_range(0, spread * 2)) - spread;
        dy = $signed($urandom_range(0, spread * 2)) - spread;
        fs = $signed($urandom_range(0, 3400)) - 1200;
        fe = $signed($urandom_range(0, 3400)) - 1200;
        if ($urandom_range(3) == 0 && fs > fe)
        begin
            t  = fs;
            fs = fe;
            fe = t;
        end
        return build_pair(sx, sy, sx + dx, sy + dy,
                          sx + (dx * fs) / 1024 + $signed($urandom_range(0, 2 * noise)) - noise,
                          sy + (dy * fs) / 1024 + $signed($urandom_range(0, 2 * noise)) - noise,
                          sx + (dx * fe) / 1024 + $signed($urandom_range(0, 2 * noise)) - noise,
                          sy + (dy * fe) / 1024 + $signed($urandom_range(0, 2 * noise)) - noise);
    endfunction

    function automatic in_t noise_pair();
        in_t p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return p;
    endfunction

    task automatic random_mix(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 10)
                send_item(noise_pair());
            else if (r < 40)
                send_item(near_pair(1 << 20, $urandom_range(0, 300)));
            else if (r < 70)
                send_item(near_pair(1 << 12, $urandom_range(0, 40)));
            else
                send_item(near_pair(64, $urandom_range(0, 4)));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        longint mx;
        longint mn;
        mx = (1 << 23) - 1;
        mn = -(1 << 23);
        // plain overlap, new lies on the reference
        send_item(build_pair(0, 0, 10240, 0, 1024, 0, 9216, 0));
        // zero-length reference
        send_item(build_pair(500, 500, 500, 500, mx, mn, mn, mx));
        // zero-length new segment on the line and off it
        send_item(build_pair(0, 0, 10240, 0, 2000, 0, 2000, 0));
        send_item(build_pair(0, 0, 10240, 0, 2000, 5000, 2000, 5000));
        // opposite direction
        send_item(build_pair(0, 0, 10240, 0, 9216, 0, 1024, 0));
        // slightly rotated: just inside and outside four degrees
        send_item(build_pair(0, 0, 100000, 0, 0, 0, 100000, 6900));
        send_item(build_pair(0, 0, 100000, 0, 0, 0, 100000, 7100));
        // too far from line
        send_item(build_pair(0, 0, 10240, 0, 0, 200, 10240, 200));
        // both before the start: near and far
        send_item(build_pair(0, 0, 10240, 0, -3000, 0, -50, 0));
        send_item(build_pair(0, 0, 10240, 0, -3000, 0, -500, 0));
        // start before, end after
        send_item(build_pair(0, 0, 10240, 0, -3000, 0, 20000, 0));
        // beyond the end: near and far
        send_item(build_pair(0, 0, 10240, 0, 10300, 0, 20000, 0));
        send_item(build_pair(0, 0, 10240, 0, 11000, 0, 20000, 0));
        // coordinate extremes
        send_item(build_pair(mn, mn, mx, mx, mn, mn, mx, mx));
        send_item(build_pair(mx, mx, mn, mn, mx, mn, mn, mx));
        send_item(build_pair(mn, mx, mx, mn, mn, mx, mx, mn));
        send_item(build_pair(mx, 0, mn, 0, mn, 0, mx, 0));
        send_item(build_pair(-1, -1, 0, 0, -1, -1, 0, 0));
        drain();
    endtask

    task automatic test_limit_sweep();
        logic [CFG_DATA_W-1:0] hv[5] = '{16'd0, 16'd728, 16'd16384, 16'hFFFF, 16'h5A5A};
        logic [CFG_DATA_W-1:0] dv[5] = '{16'd0, 16'd102, 16'hFFFF, 16'h0005, 16'hA5A5};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_cfg(CFG_HEADING, hv[ph]);
            write_cfg(CFG_LINE_DIST, dv[ph]);
            write_cfg(CFG_END_GAP, dv[(ph + 2) % 5]);
            random_mix(110);
            drain();
        end
        write_cfg(CFG_HEADING, 16'($urandom));
        write_cfg(CFG_LINE_DIST, 16'($urandom));
        write_cfg(CFG_END_GAP, 16'($urandom));
        random_mix(100);
        drain();
    endtask

    task automatic test_back_to_back();
        write_cfg(CFG_HEADING, 16'd728);
        write_cfg(CFG_LINE_DIST, 16'd102);
        write_cfg(CFG_END_GAP, 16'd102);
        quiet = 1'b1;
        random_mix(200);
        quiet = 1'b0;
        drain();
    endtask

    task automatic test_hold_off();
        quiet        = 1'b1;
        hold_off_req = 1'b1;
        random_mix(120);
        quiet = 1'b0;
        random_mix(100);
        drain();
    endtask

    task automatic test_random_defaults();
        random_mix(250);
        drain();
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_HEADING;
        cfg_data     = '0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        hold_off_left = 0;
        error_count  = 0;
        lim_heading   = HEADING_RESET;
        lim_line_dist = DIST_RESET;
        lim_end_gap   = DIST_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_random_defaults();
        test_limit_sweep();
        test_back_to_back();
        test_hold_off();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule

### line_segment_overlap_test_unit.f
src/lsot_pkg.sv
src/lsot_geom.sv
src/lsot_thresh.sv
src/lsot_cordic.sv
src/line_segment_overlap_test_unit.sv
tb/tb_line_segment_overlap_test_unit.sv
